/* rtl/ppeq_pkg.sv */
// ----------------------------------------------------------------------------
// ppeq_pkg
// Shared widths, codes, command type and saturation helpers for the
// parametric peak equalizer.
// ----------------------------------------------------------------------------
package ppeq_pkg;

  localparam int SAMPLE_WIDTH   = 24;
  localparam int COEF_FRAC_BITS = 22;
  localparam int STATE_WIDTH    = 32;

  localparam int COEF_WIDTH     = 25;
  localparam int GAIN_WIDTH     = 24;
  localparam int GAIN_FRAC_BITS = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = (COEF_WIDTH > GAIN_WIDTH) ? COEF_WIDTH : GAIN_WIDTH;

  localparam logic [CFG_INDEX_W-1:0] REG_ALLPASS_COEF = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_COEF  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BOOST_GAIN   = 2'd2;

  localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = GAIN_WIDTH'(1) << GAIN_FRAC_BITS;

  // Multiplier operand widths: coefficient or zero-extended gain, by a
  // state word or the (input - allpass) difference.
  localparam int MUL_A_W  = (COEF_WIDTH > GAIN_WIDTH + 1) ? COEF_WIDTH : GAIN_WIDTH + 1;
  localparam int MUL_B_W  = STATE_WIDTH + 1;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int MIN_FRAC = (COEF_FRAC_BITS < GAIN_FRAC_BITS) ? COEF_FRAC_BITS
                                                               : GAIN_FRAC_BITS;
  localparam int RES_W    = PROD_W + 1 - MIN_FRAC;
  localparam int WIDE_W   = RES_W + 2;

  typedef enum logic [1:0] {
    MUL_EZ1 = 2'd0,
    MUL_AZ2 = 2'd1,
    MUL_AW  = 2'd2,
    MUL_GD  = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     mul_en;
    logic     cap_ez1;
    logic     cap_w;
    logic     cap_y;
    logic     cap_out;
  } ppeq_cmd_t;

  function automatic logic signed [STATE_WIDTH-1:0] sat_state(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = {{(WIDE_W-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[STATE_WIDTH-1:0];
    end else if (v < lo) begin
      return lo[STATE_WIDTH-1:0];
    end
    return v[STATE_WIDTH-1:0];
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = {{(WIDE_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[SAMPLE_WIDTH-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_WIDTH-1:0];
    end
    return v[SAMPLE_WIDTH-1:0];
  endfunction

endpackage

/* rtl/ppeq_in_if.sv */
// ----------------------------------------------------------------------------
// ppeq_in_if
// Input sample channel: valid/ready handshake with sample and skip flag.
// ----------------------------------------------------------------------------
interface ppeq_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [ppeq_pkg::SAMPLE_WIDTH-1:0]   sample_in;
  logic                                       skip;

  modport source (output valid, sample_in, skip, input ready);
  modport sink   (input valid, sample_in, skip, output ready);
endinterface

/* rtl/ppeq_out_if.sv */
// ----------------------------------------------------------------------------
// ppeq_out_if
// Output sample channel: valid/ready handshake with the equalized sample.
// ----------------------------------------------------------------------------
interface ppeq_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [ppeq_pkg::SAMPLE_WIDTH-1:0]   sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

/* rtl/ppeq_mul.sv */
// ----------------------------------------------------------------------------
// ppeq_mul
// Shared signed multiplier with round-half-up scaling and a registered
// result. The scale is the coefficient or the gain fraction width.
// ----------------------------------------------------------------------------
module ppeq_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [ppeq_pkg::MUL_A_W-1:0]   opa,
  input  logic signed [ppeq_pkg::MUL_B_W-1:0]   opb,
  input  logic                                  gain_scale,
  output logic signed [ppeq_pkg::RES_W-1:0]     prod
);

  localparam logic signed [ppeq_pkg::PROD_W:0] HALF_COEF =
    (ppeq_pkg::PROD_W+1)'(1) <<< (ppeq_pkg::COEF_FRAC_BITS - 1);
  localparam logic signed [ppeq_pkg::PROD_W:0] HALF_GAIN =
    (ppeq_pkg::PROD_W+1)'(1) <<< (ppeq_pkg::GAIN_FRAC_BITS - 1);

  logic signed [ppeq_pkg::PROD_W-1:0] full;
  logic signed [ppeq_pkg::PROD_W:0]   rnd_coef;
  logic signed [ppeq_pkg::PROD_W:0]   rnd_gain;
  logic signed [ppeq_pkg::PROD_W:0]   sh_coef;
  logic signed [ppeq_pkg::PROD_W:0]   sh_gain;
  logic signed [ppeq_pkg::RES_W-1:0]  prod_next;

  assign full     = opa * opb;
  assign rnd_coef = (ppeq_pkg::PROD_W+1)'(full) + HALF_COEF;
  assign rnd_gain = (ppeq_pkg::PROD_W+1)'(full) + HALF_GAIN;
  assign sh_coef  = rnd_coef >>> ppeq_pkg::COEF_FRAC_BITS;
  assign sh_gain  = rnd_gain >>> ppeq_pkg::GAIN_FRAC_BITS;

  always_comb begin
    if (gain_scale) begin
      prod_next = sh_gain[ppeq_pkg::RES_W-1:0];
    end else begin
      prod_next = sh_coef[ppeq_pkg::RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
    end
  end

endmodule

/* rtl/ppeq_datapath.sv */
// ----------------------------------------------------------------------------
// ppeq_datapath
// Configuration registers, allpass delay words, working registers and the
// output register. Steps are driven one command at a time by the controller.
// ----------------------------------------------------------------------------
module ppeq_datapath (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [ppeq_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [ppeq_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic signed [ppeq_pkg::SAMPLE_WIDTH-1:0] sample_in,
  input  logic                                     skip,
  input  ppeq_pkg::ppeq_cmd_t                      cmd,
  output logic signed [ppeq_pkg::SAMPLE_WIDTH-1:0] sample_out
);

  localparam int WW = ppeq_pkg::WIDE_W;

  logic signed [ppeq_pkg::COEF_WIDTH-1:0]   allpass_coef;
  logic signed [ppeq_pkg::COEF_WIDTH-1:0]   center_coef;
  logic        [ppeq_pkg::GAIN_WIDTH-1:0]   boost_gain;

  logic signed [ppeq_pkg::STATE_WIDTH-1:0]  delay_one;
  logic signed [ppeq_pkg::STATE_WIDTH-1:0]  delay_two;

  logic signed [ppeq_pkg::SAMPLE_WIDTH-1:0] x;
  logic                                     skip_r;
  logic signed [ppeq_pkg::RES_W-1:0]        ez1;
  logic signed [ppeq_pkg::STATE_WIDTH-1:0]  w;
  logic signed [ppeq_pkg::STATE_WIDTH-1:0]  y;
  logic signed [ppeq_pkg::MUL_B_W-1:0]      diff;

  logic signed [ppeq_pkg::MUL_A_W-1:0]      opa;
  logic signed [ppeq_pkg::MUL_B_W-1:0]      opb;
  logic                                     gain_scale;
  logic signed [ppeq_pkg::RES_W-1:0]        prod;

  logic signed [WW-1:0]                     x_w;
  logic signed [WW-1:0]                     ez1_w;
  logic signed [WW-1:0]                     prod_w;
  logic signed [WW-1:0]                     z2_w;
  logic signed [WW-1:0]                     y_w;
  logic signed [ppeq_pkg::STATE_WIDTH-1:0]  w_next;
  logic signed [ppeq_pkg::STATE_WIDTH-1:0]  y_next;
  logic signed [WW-1:0]                     v;
  logic signed [WW-1:0]                     half_v;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      allpass_coef <= '0;
      center_coef  <= '0;
      boost_gain   <= ppeq_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ppeq_pkg::REG_ALLPASS_COEF: allpass_coef <= cfg_data[ppeq_pkg::COEF_WIDTH-1:0];
        ppeq_pkg::REG_CENTER_COEF:  center_coef  <= cfg_data[ppeq_pkg::COEF_WIDTH-1:0];
        ppeq_pkg::REG_BOOST_GAIN:   boost_gain   <= cfg_data[ppeq_pkg::GAIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    gain_scale = 1'b0;
    case (cmd.mul_sel)
      ppeq_pkg::MUL_EZ1: begin
        opa = ppeq_pkg::MUL_A_W'(center_coef);
        opb = ppeq_pkg::MUL_B_W'(delay_one);
      end
      ppeq_pkg::MUL_AZ2: begin
        opa = ppeq_pkg::MUL_A_W'(allpass_coef);
        opb = ppeq_pkg::MUL_B_W'(delay_two);
      end
      ppeq_pkg::MUL_AW: begin
        opa = ppeq_pkg::MUL_A_W'(allpass_coef);
        opb = ppeq_pkg::MUL_B_W'(w);
      end
      ppeq_pkg::MUL_GD: begin
        opa        = ppeq_pkg::MUL_A_W'($signed({1'b0, boost_gain}));
        opb        = diff;
        gain_scale = 1'b1;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  ppeq_mul u_mul (
    .clk        (clk),
    .en         (cmd.mul_en),
    .opa        (opa),
    .opb        (opb),
    .gain_scale (gain_scale),
    .prod       (prod)
  );

  assign x_w    = WW'(x);
  assign ez1_w  = WW'(ez1);
  assign prod_w = WW'(prod);
  assign z2_w   = WW'(delay_two);
  assign y_w    = WW'(y);

  assign w_next = ppeq_pkg::sat_state(x_w + ez1_w - prod_w);
  assign y_next = ppeq_pkg::sat_state(prod_w - ez1_w + z2_w);
  assign v      = x_w + y_w + prod_w;
  assign half_v = (v + WW'(1)) >>> 1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x      <= sample_in;
      skip_r <= skip;
    end
    if (cmd.cap_ez1) begin
      ez1 <= prod;
    end
    if (cmd.cap_w) begin
      w <= w_next;
    end
    if (cmd.cap_y) begin
      y    <= y_next;
      diff <= ppeq_pkg::MUL_B_W'(x) - ppeq_pkg::MUL_B_W'(y_next);
    end
    if (cmd.cap_out) begin
      sample_out <= skip_r ? '0 : ppeq_pkg::sat_sample(half_v);
    end
  end

  // Advance the allpass delay line once per non-skipped sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_one <= '0;
      delay_two <= '0;
    end else if (cmd.cap_y) begin
      delay_two <= delay_one;
      delay_one <= w;
    end
  end

endmodule

/* rtl/ppeq_ctrl.sv */
// ----------------------------------------------------------------------------
// ppeq_ctrl
// Sequencer for one sample: four passes through the shared multiplier with
// add and saturate steps between, then a hold until the output is free; a skipped sample goes straight to the hold.
// ----------------------------------------------------------------------------
module ppeq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_skip,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  output ppeq_pkg::ppeq_cmd_t  cmd
);

  typedef enum logic [7:0] {
    IDLE   = 8'b0000_0001,
    MUL_1  = 8'b0000_0010,
    MUL_2  = 8'b0000_0100,
    CALC_W = 8'b0000_1000,
    MUL_3  = 8'b0001_0000,
    CALC_Y = 8'b0010_0000,
    MUL_4  = 8'b0100_0000,
    FINISH = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = ppeq_pkg::MUL_EZ1;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = in_skip ? FINISH : MUL_1;
        end
      end
      MUL_1: begin
        cmd.mul_sel = ppeq_pkg::MUL_EZ1;
        cmd.mul_en  = 1'b1;
        state_next  = MUL_2;
      end
      MUL_2: begin
        cmd.cap_ez1 = 1'b1;
        cmd.mul_sel = ppeq_pkg::MUL_AZ2;
        cmd.mul_en  = 1'b1;
        state_next  = CALC_W;
      end
      CALC_W: begin
        cmd.cap_w  = 1'b1;
        state_next = MUL_3;
      end
      MUL_3: begin
        cmd.mul_sel = ppeq_pkg::MUL_AW;
        cmd.mul_en  = 1'b1;
        state_next  = CALC_Y;
      end
      CALC_Y: begin
        cmd.cap_y  = 1'b1;
        state_next = MUL_4;
      end
      MUL_4: begin
        cmd.mul_sel = ppeq_pkg::MUL_GD;
        cmd.mul_en  = 1'b1;
        state_next  = FINISH;
      end
      FINISH: begin
        // hold until the previous result has been taken
        if (out_free) begin
          cmd.cap_out = 1'b1;
          state_next  = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.cap_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.cap_out |-> (!out_valid || out_ready))
    else $error("result register written while a request is still pending");

  a_skip_short: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_skip) |=> (state == FINISH))
    else $error("skipped request did not go straight to finish");

  a_full_path: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !in_skip) |=> (state == MUL_1))
    else $error("request did not start the multiply sequence");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.cap_out |=> out_valid)
    else $error("result captured but not presented");

endmodule

/* rtl/parametric_peak_equalizer_core.sv */
// Each request makes four passes through the single shared multiplier with add/saturate
// steps between them; a skipped request goes straight to the output hold. The next
// request is taken only once the previous result is in the output register.
// A finished result waits in the output register while the next request is taken.
// Reset (rst, synchronous): delay words cleared, coefficients 0, gain 1.0, no result pending.
// ----------------------------------------------------------------------------
// parametric_peak_equalizer_core
// Second-order allpass peak/notch equalizer with saturating state and output.
// ----------------------------------------------------------------------------
module parametric_peak_equalizer_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ppeq_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ppeq_pkg::CFG_DATA_W-1:0]   cfg_data,
  ppeq_in_if.sink                           din,
  ppeq_out_if.source                        dout
);

  ppeq_pkg::ppeq_cmd_t cmd;
  logic                in_ready;
  logic                out_valid;

  ppeq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_skip   (din.skip),
    .in_ready  (in_ready),
    .out_ready (dout.ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ppeq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (din.sample_in),
    .skip       (din.skip),
    .cmd        (cmd),
    .sample_out (dout.sample_out)
  );

  assign din.ready  = in_ready;
  assign dout.valid = out_valid;

endmodule

/* verif/ppeq_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppeq_checker
// Watches the register port and both sample channels. Keeps its own copy of
// the equalizer state and predicts each output. Compares every accepted
// output with the oldest prediction.
// ----------------------------------------------------------------------------
module ppeq_checker
  import ppeq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ppeq_in_if                     din,
  ppeq_out_if                    dout,
  output int                     pending,
  output int                     errors,
  output int                     checked
);

  logic signed [COEF_WIDTH-1:0]   ap_coef;
  logic signed [COEF_WIDTH-1:0]   ctr_coef;
  logic        [GAIN_WIDTH-1:0]   band_gain;
  logic signed [STATE_WIDTH-1:0]  z1;
  logic signed [STATE_WIDTH-1:0]  z2;
  logic signed [SAMPLE_WIDTH-1:0] expected_out[$];
  int                             err_cnt = 0;
  int                             chk_cnt = 0;

  assign errors  = err_cnt;
  assign checked = chk_cnt;

  // floor(k * v / 2^frac + 1/2); all operands fit well inside 64 bits
  function automatic longint round_scale(input longint k, input longint v, input int frac);
    longint p;
    p = k * v + (longint'(1) <<< (frac - 1));
    return p >>> frac;
  endfunction

  function automatic longint clamp_signed(input longint v, input int width);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (width - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // Advance the allpass state and return the equalized sample.
  function automatic logic signed [SAMPLE_WIDTH-1:0] equalize(
    input logic signed [SAMPLE_WIDTH-1:0] x_in,
    input logic                           skip_in
  );
    longint x;
    longint ez;
    longint w;
    longint y;
    longint v;
    if (skip_in) begin
      return '0;
    end
    x  = longint'(x_in);
    ez = round_scale(ctr_coef, z1, COEF_FRAC_BITS);
    w  = clamp_signed(x + ez - round_scale(ap_coef, z2, COEF_FRAC_BITS), STATE_WIDTH);
    y  = clamp_signed(round_scale(ap_coef, w, COEF_FRAC_BITS) - ez + z2, STATE_WIDTH);
    z2 = z1;
    z1 = w[STATE_WIDTH-1:0];
    v  = x + y + round_scale(band_gain, x - y, GAIN_FRAC_BITS);
    return SAMPLE_WIDTH'(clamp_signed((v + 1) >>> 1, SAMPLE_WIDTH));
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_WIDTH-1:0] want;
    if (rst) begin
      ap_coef   = '0;
      ctr_coef  = '0;
      band_gain = GAIN_RESET;
      z1        = '0;
      z2        = '0;
      expected_out.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ALLPASS_COEF: ap_coef   = cfg_data;
          REG_CENTER_COEF:  ctr_coef  = cfg_data;
          REG_BOOST_GAIN:   band_gain = cfg_data[GAIN_WIDTH-1:0];
          default: ;
        endcase
      end
      if (dout.valid && dout.ready) begin
        if (expected_out.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected sample_out %0d with no request outstanding",
                   $time, dout.sample_out);
        end else begin
          want = expected_out.pop_front();
          chk_cnt++;
          if (dout.sample_out !== want) begin
            err_cnt++;
            $display("%0t: sample_out mismatch, expected %0d, got %0d",
                     $time, want, dout.sample_out);
          end
        end
      end
      if (din.valid && din.ready) begin
        expected_out.push_back(equalize(din.sample_in, din.skip));
      end
    end
    pending <= expected_out.size();
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the parametric peak equalizer. Drives directed
// corner samples under the reset and extreme register settings, then random samples under
// random stable and unrestricted coefficient sets, with random gaps and
// stalls on both channels. Checking lives in ppeq_checker.
// ----------------------------------------------------------------------------
module tb;
  import ppeq_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [COEF_WIDTH-1:0]   CMAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic signed [COEF_WIDTH-1:0]   CMIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};
  localparam int COEF_ONE      = 1 << COEF_FRAC_BITS;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_LEN     = 143;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_CYCLES  = 20;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ppeq_in_if  din_ch ();
  ppeq_out_if dout_ch ();

  int pending;
  int errors;
  int checked;
  int sent     = 0;
  int skipped  = 0;
  int writes   = 0;
  int settings = 1;
  int hold_req = 0;
  bit quiet_src  = 1'b0;
  bit quiet_sink = 1'b0;

  parametric_peak_equalizer_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din_ch),
    .dout      (dout_ch)
  );

  ppeq_checker eq_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din_ch),
    .dout      (dout_ch),
    .pending   (pending),
    .errors    (errors),
    .checked   (checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    writes++;
  endtask

  // Drop valid and hold until every predicted output has been taken.
  task automatic wait_drained();
    @(negedge clk);
    din_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic apply_setting(input logic signed [COEF_WIDTH-1:0] ap,
                               input logic signed [COEF_WIDTH-1:0] ctr,
                               input logic [CFG_DATA_W-1:0]        gain_word);
    wait_drained();
    write_reg(REG_ALLPASS_COEF, ap);
    write_reg(REG_CENTER_COEF, ctr);
    write_reg(REG_BOOST_GAIN, gain_word);
    settings++;
  endtask

  // Valid stays high from one request to the next when there is no gap.
  task automatic send(input logic signed [SAMPLE_WIDTH-1:0] smp, input logic skp);
    int gap;
    gap = quiet_src ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      din_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    din_ch.valid     <= 1'b1;
    din_ch.sample_in <= smp;
    din_ch.skip      <= skp;
    @(posedge clk);
    while (!din_ch.ready) @(posedge clk);
    sent++;
    if (skp) begin
      skipped++;
    end
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return SMAX;
      1:       return SMIN;
      2, 3:    return SAMPLE_WIDTH'(int'($urandom_range(0, 511)) - 256);
      default: return SAMPLE_WIDTH'($urandom());
    endcase
  endfunction

  // Output side: random stall per request, plus one long hold on request.
  initial begin
    int stall;
    dout_ch.ready <= 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req > 0) begin
        dout_ch.ready <= 1'b0;
        repeat (hold_req) @(negedge clk);
        hold_req = 0;
      end else begin
        stall = quiet_sink ? 0 : $urandom_range(0, 10);
        if (stall > 0) begin
          dout_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      dout_ch.ready <= 1'b1;
      @(posedge clk);
      while (!dout_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int                    ap;
    int                    ctr;
    int                    span;
    logic [CFG_DATA_W-1:0] gain_word;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_ALLPASS_COEF;
    cfg_data         <= '0;
    din_ch.valid     <= 1'b0;
    din_ch.sample_in <= '0;
    din_ch.skip      <= 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset setting: zero coefficients, unity gain
    send(SMAX, 1'b0);
    send(SMIN, 1'b0);
    send('0, 1'b0);
    send('1, 1'b0);
    send(SAMPLE_WIDTH'(1), 1'b0);
    send(SMAX, 1'b1);
    send(SMIN, 1'b0);

    // largest coefficients and gain: drive state and output into saturation
    apply_setting(CMAX, CMIN, CFG_DATA_W'(24'hFFFFFF));
    send(SMAX, 1'b0);
    send(SMAX, 1'b0);
    send(SMAX, 1'b0);
    send(SMIN, 1'b0);
    send(SMIN, 1'b0);
    send('0, 1'b1);
    send(SMIN, 1'b0);
    send(SAMPLE_WIDTH'(12345), 1'b0);

    // opposite extremes with zero gain
    apply_setting(CMIN, CMAX, '0);
    send(SMIN, 1'b0);
    send(SMIN, 1'b0);
    send(SMAX, 1'b0);
    send('1, 1'b1);
    send(SMAX, 1'b0);

    // spare index is ignored, gain bit above its width is dropped
    wait_drained();
    write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
    write_reg(REG_BOOST_GAIN, {1'b1, GAIN_RESET});
    settings++;
    send(SMAX, 1'b0);
    send(SAMPLE_WIDTH'(-4096), 1'b0);
    send(SMIN, 1'b0);
    send(SAMPLE_WIDTH'(777), 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if ($urandom_range(0, 3) != 0) begin
        // stable section: -1 <= a < 1, |e| <= 1 + a
        ap   = int'($urandom_range(0, 2 * COEF_ONE - 1)) - COEF_ONE;
        span = ap + COEF_ONE;
        ctr  = int'($urandom_range(0, 2 * span)) - span;
      end else begin
        ap  = $urandom();
        ctr = $urandom();
      end
      if ($urandom_range(0, 3) == 0) begin
        gain_word = CFG_DATA_W'($urandom());
      end else begin
        gain_word = CFG_DATA_W'($urandom_range(0, 4 << GAIN_FRAC_BITS));
      end
      apply_setting(COEF_WIDTH'(ap), COEF_WIDTH'(ctr), gain_word);
      quiet_src  = ($urandom_range(0, 3) == 0);
      quiet_sink = ($urandom_range(0, 3) == 0);
      if (p == 0) begin
        // hold the output side while requests keep coming
        quiet_src = 1'b1;
        hold_req  = HOLD_CYCLES;
      end
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (p == 1 && i == PHASE_LEN / 2) begin
          wait_drained();
        end
        send(pick_sample(), $urandom_range(0, 9) == 0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d samples (%0d skipped) under %0d register settings, %0d writes.",
             sent, skipped, settings, writes);
    $display("Compared %0d equalized outputs against the prediction.", checked);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: outputs still outstanding");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
